@@ rtl/core/triangle_scanline_filler_defines.svh @@
// Assertion helpers for the scanline filler.
`ifndef TRIANGLE_SCANLINE_FILLER_DEFINES_SVH
`define TRIANGLE_SCANLINE_FILLER_DEFINES_SVH
`ifndef SYNTHESIS
`define TSF_ASSERT_IMPL(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: check failed");
`define TSF_ASSERT_NORST(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("%m: check failed");
`else
`define TSF_ASSERT_IMPL(label, clk, rst, prop)
`define TSF_ASSERT_NORST(label, clk, prop)
`endif
`endif

@@ rtl/core/tsf_pkg.sv @@
package tsf_pkg;
   localparam int TileRowsDefault  = 64;
   localparam int CoordBitsDefault = 10;
   localparam int FracBits         = 16;
   // sign + integer part (up to 16 coord bits + growth) + fraction
   localparam int AccBits          = 36;
   localparam int SlopeBits        = 36;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_DIV13,
      BK_MUL4,
      BK_DIVU,
      BK_RUNU,
      BK_DIVL,
      BK_RUNL
   } bk_state_type;
endpackage

@@ rtl/core/triangle_scanline_filler.sv @@
// Scanline triangle filler.
// req_ channel: one word is a triangle, three vertices (x, y) in a tile.
// Vertex y values are clamped, vertices sorted by y; flat triangles are dropped in the front.
// A two-entry queue decouples the front from the back end.
// rsp_ channel: one word per span, row from top y up to bottom y - 1;
// tlast marks the last span of a triangle.
// The back end uses one shared serial divider with a 28-bit quotient at
// default widths. Long-edge slope, split column and the two slopes of the
// first half come before the first span word; then one span per cycle
// while rsp_tready is high.
// After an upper half the lower half needs two more divisions, so a two-half
// triangle holds the back end longer than a one-half triangle; a flat
// triangle is dropped in the front and never reaches the back end.
// Reset clears the queue, the sequencer and the output valid flag.
// If rsp_tready is low the span register holds and stepping pauses; the
// front keeps taking triangles until the queue is full.
module triangle_scanline_filler #(
   parameter int TILE_ROWS  = tsf_pkg::TileRowsDefault,
   parameter int COORD_BITS = tsf_pkg::CoordBitsDefault
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // a_x, a_y, b_x, b_y, c_x, c_y from bit 0 up, zero padded
   input  logic [((3*(COORD_BITS+$clog2(TILE_ROWS))+7)/8)*8-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // span_left, span_right, span_row from bit 0 up, zero padded
   output logic [((2*COORD_BITS+$clog2(TILE_ROWS)+7)/8)*8-1:0] rsp_tdata,
   output logic rsp_tlast
);
   `include "triangle_scanline_filler_defines.svh"
   import tsf_pkg::*;
   localparam int YB = $clog2(TILE_ROWS);
   localparam int C  = COORD_BITS;
   localparam int OW = ((2*C+YB+7)/8)*8;

   logic         q_valid, q_pop;
   logic [C-1:0] x1, x2, x3, sl, sr;
   logic [YB-1:0] y1, y2, y3, row;

   tsf_front #(.TileRows(TILE_ROWS), .CoordBits(C), .YBits(YB)) u_front (
      .clock(clock), .reset(reset), .in_valid(req_tvalid), .in_ready(req_tready),
      .ax(req_tdata[C-1:0]), .ay(req_tdata[C+YB-1:C]),
      .bx(req_tdata[2*C+YB-1:C+YB]), .by(req_tdata[2*C+2*YB-1:2*C+YB]),
      .cx(req_tdata[3*C+2*YB-1:2*C+2*YB]), .cy(req_tdata[3*C+3*YB-1:3*C+2*YB]),
      .q_valid(q_valid), .q_pop(q_pop),
      .x1(x1), .x2(x2), .x3(x3), .y1(y1), .y2(y2), .y3(y3));

   tsf_back #(.CoordBits(C), .YBits(YB)) u_back (
      .clock(clock), .reset(reset), .q_valid(q_valid), .q_pop(q_pop),
      .x1(x1), .x2(x2), .x3(x3), .y1(y1), .y2(y2), .y3(y3),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_left(sl), .out_right(sr), .out_row(row), .out_last(rsp_tlast));

   assign rsp_tdata = OW'({row, sr, sl});

   `TSF_ASSERT_IMPL(a_hold, clock, reset,
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
   `TSF_ASSERT_IMPL(a_order, clock, reset,
      rsp_tvalid |-> rsp_tdata[C-1:0] <= rsp_tdata[2*C-1:C])
   `TSF_ASSERT_NORST(a_rst, clock, $past(reset) |-> !rsp_tvalid)
endmodule

@@ rtl/core/tsf_div.sv @@
// Signed restoring divider, one quotient bit per cycle, truncates toward zero.
// Numerator is dx * 2^16, denominator dy > 0.
module tsf_div #(
   parameter int NumBits = 28,
   parameter int DenBits = 7
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic signed [NumBits-1:0]   num,
   input  logic        [DenBits-1:0]   den,
   output logic                        done,
   output logic signed [NumBits-1:0]   quot
);
   localparam int CntBits = $clog2(NumBits + 1);

   logic [NumBits-1:0]       q_ff, q_in;
   logic [DenBits:0]         rem_ff, rem_in;
   logic [DenBits-1:0]       den_ff, den_in;
   logic                     neg_ff, neg_in;
   logic [CntBits-1:0]       cnt_ff, cnt_in;
   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [DenBits+1:0]       trial;
   logic [NumBits-1:0]       mag;

   always_comb begin
      mag     = num[NumBits-1] ? NumBits'(-num) : NumBits'(num);
      q_in    = q_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, q_ff[NumBits-1]} - {2'b00, den_ff};
      if (start) begin
         q_in    = mag;
         rem_in  = '0;
         den_in  = den;
         neg_in  = num[NumBits-1];
         cnt_in  = CntBits'(NumBits);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[DenBits+1]) begin
            rem_in = trial[DenBits:0];
            q_in   = {q_ff[NumBits-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[DenBits-1:0], q_ff[NumBits-1]};
            q_in   = {q_ff[NumBits-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntBits'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      q_ff   <= q_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   assign done = done_ff;
   assign quot = neg_ff ? NumBits'(-q_ff) : NumBits'(q_ff);
endmodule

@@ rtl/core/tsf_front.sv @@
// Front: clamps y and sorts vertices, drops flat triangles, pushes to a 2-deep queue.
module tsf_front #(
   parameter int TileRows  = tsf_pkg::TileRowsDefault,
   parameter int CoordBits = tsf_pkg::CoordBitsDefault,
   parameter int YBits     = 6
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [CoordBits-1:0]  ax, bx, cx,
   input  logic [YBits-1:0]      ay, by, cy,
   output logic                  q_valid,
   input  logic                  q_pop,
   output logic [CoordBits-1:0]  x1, x2, x3,
   output logic [YBits-1:0]      y1, y2, y3
);
   localparam int W = 3 * (CoordBits + YBits);
   localparam logic [YBits-1:0] YMax = YBits'(TileRows - 1);

   logic [W-1:0]     mem_ff [2];
   logic             wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic [YBits-1:0] ya, yb, yc, t1, t2, t3, s1, s2, s3;
   logic [CoordBits-1:0] u1, u2, u3, r1, r2, r3;
   logic             push, pop;
   logic [W-1:0]     word;

   always_comb begin
      ya = (ay > YMax) ? YMax : ay;
      yb = (by > YMax) ? YMax : by;
      yc = (cy > YMax) ? YMax : cy;
      // stable three-element sort
      t1 = ya; u1 = ax; t2 = yb; u2 = bx; t3 = yc; u3 = cx;
      if (t1 > t2) begin
         s1 = t2; r1 = u2; s2 = t1; r2 = u1;
      end else begin
         s1 = t1; r1 = u1; s2 = t2; r2 = u2;
      end
      s3 = t3; r3 = u3;
      if (s2 > s3) begin
         s3 = s2; r3 = r2; s2 = t3; r2 = u3;
         if (s1 > s2) begin
            s2 = s1; r2 = r1; s1 = t3; r1 = u3;
         end
      end
      word = {r1, s1, r2, s2, r3, s3};
   end

   assign in_ready = (cnt_ff != 2'd2);
   assign push     = in_valid && in_ready && (s1 != s3);
   assign pop      = q_pop && (cnt_ff != 2'd0);
   assign q_valid  = (cnt_ff != 2'd0);
   assign {x1, y1, x2, y2, x3, y3} = mem_ff[rp_ff];

   always_comb begin
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in; rp_ff <= rp_in; cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wp_ff] <= word;
   end
endmodule

@@ rtl/core/tsf_back.sv @@
// Back: 3 or 5 slope divisions on one shared divider, and span stepping.
module tsf_back #(
   parameter int CoordBits = tsf_pkg::CoordBitsDefault,
   parameter int YBits     = 6
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   output logic                  q_pop,
   input  logic [CoordBits-1:0]  x1, x2, x3,
   input  logic [YBits-1:0]      y1, y2, y3,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [CoordBits-1:0]  out_left,
   output logic [CoordBits-1:0]  out_right,
   output logic [YBits-1:0]      out_row,
   output logic                  out_last
);
   import tsf_pkg::*;
   localparam int NumBits = CoordBits + 2 + FracBits;
   localparam int A = AccBits;
   localparam logic signed [A-1:0] XMaxA = A'((1 << CoordBits) - 1);

   bk_state_type st_ff, st_in;
   logic [CoordBits-1:0] x1_ff, x1_in, x2_ff, x2_in, x3_ff, x3_in, x4_ff, x4_in;
   logic [YBits-1:0]     y1_ff, y1_in, y2_ff, y2_in, y3_ff, y3_in, row_ff, row_in;
   logic signed [A-1:0]  s13_ff, s13_in, sl_ff, sl_in, sr_ff, sr_in;
   logic signed [A-1:0]  l_ff, l_in, r_ff, r_in;
   logic                 dstart;
   logic signed [NumBits-1:0] dnum, dquot;
   logic [YBits:0]       dden;
   logic                 ddone, dphase_ff, dphase_in;
   logic signed [A+YBits+1:0] prod;
   logic signed [A-1:0]  lo, hi, tl;
   logic [CoordBits-1:0] cl, ch;
   logic                 ov_ff, ov_in, ol_ff, ol_in, last;
   logic [CoordBits-1:0] oleft_ff, oleft_in, oright_ff, oright_in;
   logic [YBits-1:0]     orow_ff, orow_in;

   tsf_div #(.NumBits(NumBits), .DenBits(YBits + 1)) u_div (
      .clock(clock), .reset(reset), .start(dstart), .num(dnum), .den(dden),
      .done(ddone), .quot(dquot));

   function automatic logic signed [NumBits-1:0] fnum(logic [CoordBits-1:0] a,
                                                      logic [CoordBits-1:0] b);
      logic signed [NumBits-1:0] d;
      d = NumBits'($signed({1'b0, a})) - NumBits'($signed({1'b0, b}));
      return d <<< FracBits;
   endfunction

   // truncate toward zero then clamp
   function automatic logic [CoordBits-1:0] tocol(logic signed [A-1:0] v);
      logic signed [A-1:0] t;
      t = (v < 0) ? -((-v) >>> FracBits) : (v >>> FracBits);
      if (t < 0) return '0;
      if (t > XMaxA) return XMaxA[CoordBits-1:0];
      return t[CoordBits-1:0];
   endfunction

   always_comb begin
      lo = (l_ff < r_ff) ? l_ff : r_ff;
      hi = (l_ff < r_ff) ? r_ff : l_ff;
      cl = tocol(lo);
      ch = tocol(hi);
      prod = (A+YBits+2)'(s13_ff) * $signed({2'b00, y2_ff - y1_ff});
      tl = (prod < 0) ? A'(-((-prod) >>> FracBits)) : A'(prod >>> FracBits);
   end

   always_comb begin
      st_in = st_ff;
      x1_in = x1_ff; x2_in = x2_ff; x3_in = x3_ff; x4_in = x4_ff;
      y1_in = y1_ff; y2_in = y2_ff; y3_in = y3_ff; row_in = row_ff;
      s13_in = s13_ff; sl_in = sl_ff; sr_in = sr_ff; l_in = l_ff; r_in = r_ff;
      dphase_in = dphase_ff;
      q_pop = 1'b0; dstart = 1'b0; dnum = '0; dden = '0;
      ov_in = ov_ff; ol_in = ol_ff;
      oleft_in = oleft_ff; oright_in = oright_ff; orow_in = orow_ff;
      last = 1'b0;
      if (ov_ff && out_ready) ov_in = 1'b0;
      case (st_ff)
         BK_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               x1_in = x1; x2_in = x2; x3_in = x3;
               y1_in = y1; y2_in = y2; y3_in = y3;
               dstart = 1'b1; dnum = fnum(x3, x1);
               dden = {1'b0, y3 - y1};
               st_in = BK_DIV13;
            end
         end
         BK_DIV13: begin
            if (ddone) begin
               s13_in = A'(dquot);
               st_in = BK_MUL4;
            end
         end
         BK_MUL4: begin
            x4_in = CoordBits'(A'(x1_ff) + tl);
            if (y2_ff > y1_ff) begin
               dstart = 1'b1; dnum = fnum(x2_ff, x1_ff);
               dden = {1'b0, y2_ff - y1_ff}; dphase_in = 1'b0;
               st_in = BK_DIVU;
            end else begin
               dstart = 1'b1; dnum = fnum(x3_ff, x2_ff);
               dden = {1'b0, y3_ff - y2_ff}; dphase_in = 1'b0;
               st_in = BK_DIVL;
            end
         end
         BK_DIVU: begin
            if (ddone && !dphase_ff) begin
               sl_in = A'(dquot);
               dstart = 1'b1; dnum = fnum(x4_ff, x1_ff);
               dden = {1'b0, y2_ff - y1_ff}; dphase_in = 1'b1;
            end else if (ddone) begin
               sr_in = A'(dquot);
               l_in = A'(x1_ff) <<< FracBits; r_in = A'(x1_ff) <<< FracBits;
               row_in = y1_ff; st_in = BK_RUNU;
            end
         end
         BK_DIVL: begin
            if (ddone && !dphase_ff) begin
               sl_in = A'(dquot);
               dstart = 1'b1; dnum = fnum(x3_ff, x4_ff);
               dden = {1'b0, y3_ff - y2_ff}; dphase_in = 1'b1;
            end else if (ddone) begin
               sr_in = A'(dquot);
               l_in = A'(x2_ff) <<< FracBits; r_in = A'(x4_ff) <<< FracBits;
               row_in = y2_ff; st_in = BK_RUNL;
            end
         end
         BK_RUNU, BK_RUNL: begin
            if (!ov_ff || out_ready) begin
               last = (st_ff == BK_RUNL) ? (row_ff + 1'b1 == y3_ff)
                      : ((row_ff + 1'b1 == y2_ff) && (y3_ff == y2_ff));
               ov_in = 1'b1; ol_in = last;
               oleft_in = cl; oright_in = ch; orow_in = row_ff;
               l_in = l_ff + sl_ff; r_in = r_ff + sr_ff;
               row_in = row_ff + 1'b1;
               if (st_ff == BK_RUNU && row_ff + 1'b1 == y2_ff) begin
                  if (y3_ff == y2_ff) st_in = BK_IDLE;
                  else begin
                     dstart = 1'b1; dnum = fnum(x3_ff, x2_ff);
                     dden = {1'b0, y3_ff - y2_ff}; dphase_in = 1'b0;
                     st_in = BK_DIVL;
                  end
               end else if (st_ff == BK_RUNL && last) st_in = BK_IDLE;
            end
         end
         default: st_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= BK_IDLE; ov_ff <= 1'b0; dphase_ff <= 1'b0;
      end else begin
         st_ff <= st_in; ov_ff <= ov_in; dphase_ff <= dphase_in;
      end
      x1_ff <= x1_in; x2_ff <= x2_in; x3_ff <= x3_in; x4_ff <= x4_in;
      y1_ff <= y1_in; y2_ff <= y2_in; y3_ff <= y3_in; row_ff <= row_in;
      s13_ff <= s13_in; sl_ff <= sl_in; sr_ff <= sr_in; l_ff <= l_in; r_ff <= r_in;
      ol_ff <= ol_in; oleft_ff <= oleft_in; oright_ff <= oright_in; orow_ff <= orow_in;
   end

   assign out_valid = ov_ff;
   assign out_left  = oleft_ff;
   assign out_right = oright_ff;
   assign out_row   = orow_ff;
   assign out_last  = ol_ff;
endmodule
